// ===== design/tlsm_pkg.sv =====
// shared types and codes for the two-list sorted merge block
// no dependencies
package tlsm_pkg;

    localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [1:0] OP_POP           = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

endpackage

// ===== design/tlsm_ctrl.sv =====
// controller for the two-list sorted merge block: item sequencing and output beat valid
// depends on tlsm_pkg
module tlsm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output tlsm_pkg::ctrl_cmd_t    cmd
);

    tlsm_pkg::ctrl_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tlsm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tlsm_pkg::ST_EXEC;
                end
            end
            tlsm_pkg::ST_EXEC: begin
                if (out_free) begin
                    state_next = tlsm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            tlsm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            tlsm_pkg::ST_EXEC: begin
                cmd.commit = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tlsm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ===== design/tlsm_dp.sv =====
// datapath for the two-list sorted merge block: list memories, pointers, head compare
// depends on tlsm_pkg
module tlsm_dp #(
    parameter int LIST_DEPTH = 32,
    parameter int VALUE_BITS = 32,
    parameter int TDATA_W    = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tlsm_pkg::ctrl_cmd_t    cmd,
    input  logic [1:0]             in_op,
    input  logic [VALUE_BITS-1:0]  in_value,
    output logic [TDATA_W-1:0]     out_data,
    output logic [2:0]             out_user
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [VALUE_BITS-1:0] first_mem_reg  [LIST_DEPTH];
    logic [VALUE_BITS-1:0] second_mem_reg [LIST_DEPTH];

    logic [AW-1:0] first_head_reg,  first_head_next;
    logic [AW-1:0] first_tail_reg,  first_tail_next;
    logic [CW-1:0] first_cnt_reg,   first_cnt_next;
    logic [AW-1:0] second_head_reg, second_head_next;
    logic [AW-1:0] second_tail_reg, second_tail_next;
    logic [CW-1:0] second_cnt_reg,  second_cnt_next;

    logic [1:0]            op_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] first_rd_reg, second_rd_reg;

    logic [VALUE_BITS-1:0] res_value_next;
    logic                  res_second_next;
    logic [1:0]            res_status_next;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic                  res_second_reg;
    logic [1:0]            res_status_reg;

    logic first_wr, second_wr;
    logic have_first, have_second, first_full, second_full, take_second;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(LIST_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign have_first  = first_cnt_reg != '0;
    assign have_second = second_cnt_reg != '0;
    assign first_full  = first_cnt_reg == CW'(LIST_DEPTH);
    assign second_full = second_cnt_reg == CW'(LIST_DEPTH);
    assign take_second = !have_first ||
                         (have_second && ($signed(first_rd_reg) > $signed(second_rd_reg)));

    always_comb begin
        first_head_next  = first_head_reg;
        first_tail_next  = first_tail_reg;
        first_cnt_next   = first_cnt_reg;
        second_head_next = second_head_reg;
        second_tail_next = second_tail_reg;
        second_cnt_next  = second_cnt_reg;
        first_wr         = 1'b0;
        second_wr        = 1'b0;
        res_value_next   = '0;
        res_second_next  = 1'b0;
        res_status_next  = tlsm_pkg::STAT_OK;
        if (cmd.commit) begin
            unique case (op_reg)
                tlsm_pkg::OP_APPEND_FIRST: begin
                    if (first_full) begin
                        res_status_next = tlsm_pkg::STAT_FULL;
                    end else begin
                        first_wr        = 1'b1;
                        first_tail_next = wrap_inc(first_tail_reg);
                        first_cnt_next  = first_cnt_reg + CW'(1);
                    end
                end
                tlsm_pkg::OP_APPEND_SECOND: begin
                    if (second_full) begin
                        res_status_next = tlsm_pkg::STAT_FULL;
                    end else begin
                        second_wr        = 1'b1;
                        second_tail_next = wrap_inc(second_tail_reg);
                        second_cnt_next  = second_cnt_reg + CW'(1);
                    end
                end
                tlsm_pkg::OP_POP: begin
                    if (!have_first && !have_second) begin
                        res_status_next = tlsm_pkg::STAT_EMPTY;
                    end else if (take_second) begin
                        res_value_next   = second_rd_reg;
                        res_second_next  = 1'b1;
                        second_head_next = wrap_inc(second_head_reg);
                        second_cnt_next  = second_cnt_reg - CW'(1);
                    end else begin
                        res_value_next  = first_rd_reg;
                        first_head_next = wrap_inc(first_head_reg);
                        first_cnt_next  = first_cnt_reg - CW'(1);
                    end
                end
                default: begin
                    res_status_next = tlsm_pkg::STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_head_reg  <= '0;
            first_tail_reg  <= '0;
            first_cnt_reg   <= '0;
            second_head_reg <= '0;
            second_tail_reg <= '0;
            second_cnt_reg  <= '0;
        end else begin
            first_head_reg  <= first_head_next;
            first_tail_reg  <= first_tail_next;
            first_cnt_reg   <= first_cnt_next;
            second_head_reg <= second_head_next;
            second_tail_reg <= second_tail_next;
            second_cnt_reg  <= second_cnt_next;
        end
    end

    // head prefetch on accept, list memories written on commit
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= in_op;
            value_reg     <= in_value;
            first_rd_reg  <= first_mem_reg[first_head_reg];
            second_rd_reg <= second_mem_reg[second_head_reg];
        end
        if (first_wr) begin
            first_mem_reg[first_tail_reg] <= value_reg;
        end
        if (second_wr) begin
            second_mem_reg[second_tail_reg] <= value_reg;
        end
        if (cmd.commit) begin
            res_value_reg  <= res_value_next;
            res_second_reg <= res_second_next;
            res_status_reg <= res_status_next;
        end
    end

    assign out_data = TDATA_W'(res_value_reg);
    assign out_user = {res_status_reg, res_second_reg};

endmodule

// ===== design/two_list_sorted_merge.sv =====
// two_list_sorted_merge: two ascending lists with append and merged pop
// result beat registered on commit in ST_EXEC after the accept, held while m_tready is low
// input: no new item is taken until the current one commits; s_tready is low in ST_EXEC
// reset: pointers and counts clear, both lists empty; memory contents stay undefined
// depends on tlsm_pkg, tlsm_ctrl, tlsm_dp
module two_list_sorted_merge #(
    parameter int LIST_DEPTH = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS + 7) / 8)*8-1:0] s_tdata,  // value
    input  logic [1:0]                          s_tuser,  // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((VALUE_BITS + 7) / 8)*8-1:0] m_tdata,  // merged_value
    output logic [2:0]                          m_tuser   // status [2:1], from_second [0]
);

    localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8;

    tlsm_pkg::ctrl_cmd_t cmd;

    tlsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tlsm_dp #(
        .LIST_DEPTH (LIST_DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .TDATA_W    (TDATA_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_op    (s_tuser),
        .in_value (s_tdata[VALUE_BITS-1:0]),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    a_empty_pop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:1] == tlsm_pkg::STAT_EMPTY) |-> (m_tdata == '0 && !m_tuser[0]))
        else $error("empty pop carries data");

    a_second_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == tlsm_pkg::STAT_OK))
        else $error("second-list flag on a failed item");
`endif

endmodule

// ===== tb/sv/tb_two_list_sorted_merge.sv =====
// self-checking testbench for two_list_sorted_merge: appends, merged pops, full and empty flags
// predicts every result beat with its own pair of list copies and checks it field by field
// depends on tlsm_pkg and two_list_sorted_merge
module tb_two_list_sorted_merge;

    localparam int LIST_DEPTH = 32;
    localparam int VALUE_BITS = 32;
    localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int NOISE_ITEMS = 150;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [VALUE_BITS-1:0] merged_value;
        logic                  from_second;
        logic [1:0]            status;
    } merge_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;   // value
    logic [1:0]        s_tuser = '0;   // op
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;        // merged_value
    logic [2:0]        m_tuser;        // status [2:1], from_second [0]

    logic signed [VALUE_BITS-1:0] first_vals[$];
    logic signed [VALUE_BITS-1:0] second_vals[$];
    merge_result_t                expected_beats[$];

    int idle_pct = 16;
    int errors = 0;
    int items_sent = 0;
    int merged_pops = 0;
    int dropped_appends = 0;
    int empty_pops = 0;
    int quiet_cycles = 0;

    two_list_sorted_merge #(
        .LIST_DEPTH(LIST_DEPTH),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic merge_result_t predict_merge(logic [1:0] op, logic [VALUE_BITS-1:0] value);
        merge_result_t r;
        logic          take_second;
        r = '0;
        case (op)
            tlsm_pkg::OP_APPEND_FIRST: begin
                if (first_vals.size() >= LIST_DEPTH) begin
                    r.status = tlsm_pkg::STAT_FULL;
                    dropped_appends++;
                end else begin
                    first_vals.push_back(value);
                end
            end
            tlsm_pkg::OP_APPEND_SECOND: begin
                if (second_vals.size() >= LIST_DEPTH) begin
                    r.status = tlsm_pkg::STAT_FULL;
                    dropped_appends++;
                end else begin
                    second_vals.push_back(value);
                end
            end
            tlsm_pkg::OP_POP: begin
                if (first_vals.size() == 0 && second_vals.size() == 0) begin
                    r.status = tlsm_pkg::STAT_EMPTY;
                    empty_pops++;
                end else begin
                    if (first_vals.size() == 0)
                        take_second = 1'b1;
                    else if (second_vals.size() == 0)
                        take_second = 1'b0;
                    else
                        take_second = first_vals[0] > second_vals[0];
                    if (take_second) begin
                        r.merged_value = second_vals.pop_front();
                        r.from_second = 1'b1;
                    end else begin
                        r.merged_value = first_vals.pop_front();
                    end
                    merged_pops++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // next value of an ascending run, saturating at the top of the range
    function automatic logic [VALUE_BITS-1:0] next_ascending(logic signed [VALUE_BITS-1:0] last);
        longint v;
        v = longint'(last);
        if ($urandom_range(3) == 0)
            v = v + longint'($urandom);
        else
            v = v + longint'($urandom_range(0, 4));
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        return v[VALUE_BITS-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] run_base();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return $urandom;
            2: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return 32'h7FFF_FFFF - 32'($urandom_range(0, 20000));
        endcase
    endfunction

    task automatic send_item(logic [1:0] op, logic [VALUE_BITS-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
        expected_beats.push_back(predict_merge(op, value));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_beats.size() != 0) @(posedge aclk);
    endtask

    task automatic drain_lists();
        while (first_vals.size() + second_vals.size() != 0)
            send_item(tlsm_pkg::OP_POP, $urandom);
        send_item(tlsm_pkg::OP_POP, $urandom);
    endtask

    task automatic test_directed_edges();
        send_item(tlsm_pkg::OP_POP, 32'h0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF);
        send_item(tlsm_pkg::OP_APPEND_FIRST, 32'h8000_0000);
        send_item(tlsm_pkg::OP_APPEND_SECOND, 32'h8000_0000);
        send_item(tlsm_pkg::OP_APPEND_FIRST, 32'h7FFF_FFFF);
        send_item(tlsm_pkg::OP_APPEND_SECOND, 32'h0);
        send_item(tlsm_pkg::OP_APPEND_SECOND, 32'h7FFF_FFFF);
        // ties go to the first list
        repeat (5) send_item(tlsm_pkg::OP_POP, 32'hFFFF_FFFF);
        send_item(tlsm_pkg::OP_POP, 32'h0);
        // out of order appends, only heads are compared
        send_item(tlsm_pkg::OP_APPEND_SECOND, 32'd5);
        send_item(tlsm_pkg::OP_APPEND_SECOND, 32'd3);
        send_item(tlsm_pkg::OP_APPEND_FIRST, 32'd4);
        send_item(OP_UNUSED, 32'h1234_5678);
        repeat (4) send_item(tlsm_pkg::OP_POP, 32'h0);
    endtask

    task automatic test_fill_and_drain();
        logic signed [VALUE_BITS-1:0] last1, last2;
        last1 = run_base();
        last2 = last1;
        repeat (LIST_DEPTH + 1) begin
            last1 = next_ascending(last1);
            send_item(tlsm_pkg::OP_APPEND_FIRST, last1);
        end
        repeat (LIST_DEPTH + 1) begin
            last2 = next_ascending(last2);
            send_item(tlsm_pkg::OP_APPEND_SECOND, last2);
        end
        wait_results_drained();
        drain_lists();
    endtask

    task automatic test_random_merges(int target);
        logic signed [VALUE_BITS-1:0] last1, last2;
        int                           len;
        int                           pick;
        while (items_sent < target) begin
            last1 = run_base();
            last2 = ($urandom_range(1) == 0) ? last1 : run_base();
            len = $urandom_range(8, 70);
            repeat (len) begin
                pick = $urandom_range(99);
                if (pick < 38) begin
                    last1 = next_ascending(last1);
                    send_item(tlsm_pkg::OP_APPEND_FIRST, last1);
                end else if (pick < 76) begin
                    last2 = next_ascending(last2);
                    send_item(tlsm_pkg::OP_APPEND_SECOND, last2);
                end else if (pick < 95) begin
                    send_item(tlsm_pkg::OP_POP, $urandom);
                end else begin
                    send_item(2'($urandom_range(3)), $urandom);
                end
            end
            drain_lists();
        end
    endtask

    task automatic test_noise(int count);
        repeat (count) send_item(2'($urandom_range(3)), $urandom);
        drain_lists();
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        merge_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.merged_value = m_tdata[VALUE_BITS-1:0];
            got.from_second = m_tuser[0];
            got.status = m_tuser[2:1];
            if (expected_beats.size() == 0) begin
                errors++;
                $error("result beat with nothing expected: merged_value %0d", got.merged_value);
            end else begin
                want = expected_beats.pop_front();
                if (got.merged_value !== want.merged_value) begin
                    errors++;
                    $error("merged_value: expected %0d, actual %0d",
                           $signed(want.merged_value), $signed(got.merged_value));
                end
                if (got.from_second !== want.from_second) begin
                    errors++;
                    $error("from_second: expected %0d, actual %0d",
                           want.from_second, got.from_second);
                end
                if (got.status !== want.status) begin
                    errors++;
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_fill_and_drain();
        test_random_merges(RANDOM_ITEMS / 2);
        // stretch with no idling on either side
        idle_pct = 0;
        test_fill_and_drain();
        test_random_merges(RANDOM_ITEMS * 2 / 3);
        idle_pct = 16;
        test_random_merges(RANDOM_ITEMS);
        test_noise(NOISE_ITEMS);

        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (expected_beats.size() != 0) begin
            errors++;
            $error("%0d expected result beats never arrived", expected_beats.size());
        end
        $display("run covered %0d items: %0d merged pops, %0d full-list drops, %0d empty pops",
                 items_sent, merged_pops, dropped_appends, empty_pops);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
